>>> hw/rtl/gpf_pkg.sv
// ----------------------------------------------------------------------------
// gpf_pkg: shared types and constants of the grid local peak finder
// Register indexes, fixed field widths and the result item layout.
// ----------------------------------------------------------------------------
package gpf_pkg;

   // configuration port
   localparam int CFG_W       = 6;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_GRID_ROWS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GRID_COLS = 2'd1;

   localparam logic [CFG_W-1:0] DIM_RESET = 6'd20;
   localparam logic [CFG_W-1:0] DIM_MIN   = 6'd2;

   // result fields
   localparam int PEAK_ROW_W = 5;
   localparam int PEAK_COL_W = 5;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_PAD_W  = RSP_DATA_W - PEAK_ROW_W - PEAK_COL_W;

   typedef struct packed {
      logic                  last;
      logic [PEAK_COL_W-1:0] col;
      logic [PEAK_ROW_W-1:0] row;
   } rsp_item_type;

endpackage

>>> hw/rtl/grid_local_peak_finder.sv
// Sequence: a sample is accepted in ST_IDLE, ST_RD1 captures its column entry,
//   ST_EXEC evaluates it, and a peak is then registered in the output register.
// Samples: a new sample is taken only in ST_IDLE, after the two reads (column c
//   and c+1) of the single read port of the column RAM; after the final sample,
//   ST_FLUSH drains the bottom-row flags first. Output stalls hold ST_EXEC and ST_FLUSH.
// Reset: synchronous; clears state, positions, flags, delay registers, sets both
//   dimensions to 20. The column RAM is not cleared (every grid writes row 0 first).
// ----------------------------------------------------------------------------
// grid_local_peak_finder: 4-neighbor local maximum detection on a raster stream
// Keeps the two previous rows per column in one RAM, decides row r-1 while
// row r streams in, and drains bottom-row peaks after the final sample.
// ----------------------------------------------------------------------------
module grid_local_peak_finder
   import gpf_pkg::*;
#(
   parameter int MAX_ROWS    = 32,
   parameter int MAX_COLS    = 32,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // sample stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((SAMPLE_BITS + 7) / 8)*8-1:0] req_tdata,  // sample
   // peak stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [RSP_DATA_W-1:0]                rsp_tdata,  // peak_row, peak_col
   output logic                                 rsp_tlast,
   // configuration writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [CSR_INDEX_W-1:0]               csr_index,
   input  logic [CFG_W-1:0]                     csr_data
);

   localparam int ROW_W   = $clog2(MAX_ROWS);
   localparam int COL_W   = $clog2(MAX_COLS);
   localparam int CMP_W   = ((ROW_W > CFG_W) ? ROW_W : CFG_W) + 1;
   localparam int ENTRY_W = 2 * SAMPLE_BITS;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RD1   = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [CFG_W-1:0]       grid_rows_ff, grid_rows_in;
   logic [CFG_W-1:0]       grid_cols_ff, grid_cols_in;
   logic [ROW_W-1:0]       pos_r_ff, pos_r_in;
   logic [COL_W-1:0]       pos_c_ff, pos_c_in;
   logic [ROW_W-1:0]       r_ff, r_in;
   logic [COL_W-1:0]       c_ff, c_in;
   logic [SAMPLE_BITS-1:0] s_ff, s_in;
   logic [ENTRY_W-1:0]     ent_c_ff, ent_c_in;
   logic [SAMPLE_BITS-1:0] nd0_ff, nd0_in;
   logic [SAMPLE_BITS-1:0] nd1_ff, nd1_in;
   logic [SAMPLE_BITS-1:0] nd2_ff, nd2_in;
   logic [MAX_COLS-1:0]    flags_ff, flags_in;
   logic [COL_W-1:0]       k_ff, k_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_item_type           rsp_item_ff, rsp_item_in;

   logic                   req_accept, csr_accept, out_free, out_load;
   rsp_item_type           out_item;
   logic [CFG_W-1:0]       rows_eff, cols_eff;
   logic [CMP_W-1:0]       rows_x, cols_x, r_x, c_x;
   logic                   pos_bad;
   logic [ROW_W-1:0]       eff_r;
   logic [COL_W-1:0]       eff_c;
   logic                   ram_rd_en, ram_wr_en;
   logic [COL_W-1:0]       ram_rd_addr;
   logic [ENTRY_W-1:0]     ram_rdata, ram_wr_data;
   logic [SAMPLE_BITS-1:0] ctr, older_c, prior_right;
   logic                   has_up, has_up2, has_left, has_left2, has_right;
   logic                   bottom, row_end, grid_end, pk;
   logic [MAX_COLS-1:0]    flags_next, k_mask;
   logic [31:0]            row_up_wide, row_cur_wide, col_cur_wide, k_wide;

   // handshakes
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_accept = csr_valid && csr_ready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // clamp dimensions into their legal range
   always_comb begin
      if (grid_rows_ff < DIM_MIN) begin
         rows_eff = DIM_MIN;
      end else if (CMP_W'(grid_rows_ff) > CMP_W'(MAX_ROWS)) begin
         rows_eff = CFG_W'(MAX_ROWS);
      end else begin
         rows_eff = grid_rows_ff;
      end
      if (grid_cols_ff < DIM_MIN) begin
         cols_eff = DIM_MIN;
      end else if (CMP_W'(grid_cols_ff) > CMP_W'(MAX_COLS)) begin
         cols_eff = CFG_W'(MAX_COLS);
      end else begin
         cols_eff = grid_cols_ff;
      end
   end

   assign rows_x = CMP_W'(rows_eff);
   assign cols_x = CMP_W'(cols_eff);

   // position of the arriving sample, restarted when out of range
   assign pos_bad = (CMP_W'(pos_r_ff) >= rows_x) || (CMP_W'(pos_c_ff) >= cols_x);
   assign eff_r   = pos_bad ? '0 : pos_r_ff;
   assign eff_c   = pos_bad ? '0 : pos_c_ff;

   // column RAM: {older row, prior row} per column
   assign ram_rd_en   = req_accept || (state_ff == ST_RD1);
   assign ram_rd_addr = (state_ff == ST_RD1) ? c_ff + COL_W'(1) : eff_c;

   gpf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_COLS)
   ) u_col_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (c_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rdata)
   );

   // neighborhood of the cell one row up
   assign r_x         = CMP_W'(r_ff);
   assign c_x         = CMP_W'(c_ff);
   assign ctr         = ent_c_ff[SAMPLE_BITS-1:0];
   assign older_c     = ent_c_ff[ENTRY_W-1:SAMPLE_BITS];
   assign prior_right = ram_rdata[SAMPLE_BITS-1:0];
   assign has_up      = (r_ff != '0);
   assign has_up2     = (r_x >= CMP_W'(2));
   assign has_left    = (c_ff != '0);
   assign has_left2   = (c_x >= CMP_W'(2));
   assign has_right   = (c_x + CMP_W'(1) < cols_x);
   assign bottom      = (r_x + CMP_W'(1) == rows_x);
   assign row_end     = (c_x + CMP_W'(1) >= cols_x);
   assign grid_end    = row_end && (r_x + CMP_W'(1) >= rows_x);

   assign pk = has_up && (ctr >= s_ff)
               && !(has_up2 && (ctr < older_c))
               && !(has_left && (ctr < nd0_ff))
               && !(has_right && (ctr < prior_right));

   assign ram_wr_data = {(has_up ? ctr : older_c), s_ff};

   // bottom-row flags after this sample; nd0 still holds the cell above c-1
   always_comb begin
      flags_next = flags_ff;
      if (bottom) begin
         if (has_left) begin
            flags_next[c_ff - COL_W'(1)] = (nd1_ff >= s_ff) && (nd1_ff >= nd0_ff)
                                           && !(has_left2 && (nd1_ff < nd2_ff));
         end
         if (row_end) begin
            flags_next[c_ff] = (s_ff >= nd1_ff) && (s_ff >= ctr);
         end
      end
   end

   assign row_up_wide  = 32'(r_ff - ROW_W'(1));
   assign row_cur_wide = 32'(r_ff);
   assign col_cur_wide = 32'(c_ff);
   assign k_wide       = 32'(k_ff);
   assign k_mask       = MAX_COLS'(1) << k_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      grid_rows_in = grid_rows_ff;
      grid_cols_in = grid_cols_ff;
      pos_r_in     = pos_r_ff;
      pos_c_in     = pos_c_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      s_in         = s_ff;
      ent_c_in     = ent_c_ff;
      nd0_in       = nd0_ff;
      nd1_in       = nd1_ff;
      nd2_in       = nd2_ff;
      flags_in     = flags_ff;
      k_in         = k_ff;
      ram_wr_en    = 1'b0;
      out_load     = 1'b0;
      out_item     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               s_in     = req_tdata[SAMPLE_BITS-1:0];
               r_in     = eff_r;
               c_in     = eff_c;
               state_in = ST_RD1;
            end
         end
         ST_RD1: begin
            // capture column c; column c+1 arrives next cycle
            ent_c_in = ram_rdata;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            // evaluate only when the output register can take a result
            if (out_free) begin
               ram_wr_en = 1'b1;
               if (pk) begin
                  out_load      = 1'b1;
                  out_item.row  = row_up_wide[PEAK_ROW_W-1:0];
                  out_item.col  = col_cur_wide[PEAK_COL_W-1:0];
                  out_item.last = grid_end ? (flags_next == '0) : 1'b1;
               end
               if (has_up) begin
                  nd0_in = ctr;
               end
               nd2_in   = nd1_ff;
               nd1_in   = s_ff;
               flags_in = flags_next;
               k_in     = '0;
               if (grid_end) begin
                  pos_r_in = '0;
                  pos_c_in = '0;
                  state_in = ST_FLUSH;
               end else if (row_end) begin
                  pos_r_in = r_ff + ROW_W'(1);
                  pos_c_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  pos_r_in = r_ff;
                  pos_c_in = c_ff + COL_W'(1);
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            // drain bottom-row peaks in column order, clearing each one sent
            if (flags_ff == '0) begin
               state_in = ST_IDLE;
            end else if (flags_ff[k_ff]) begin
               if (out_free) begin
                  out_load      = 1'b1;
                  out_item.row  = row_cur_wide[PEAK_ROW_W-1:0];
                  out_item.col  = k_wide[PEAK_COL_W-1:0];
                  out_item.last = ((flags_ff & ~k_mask) == '0);
                  flags_in      = flags_ff & ~k_mask;
                  k_in          = k_ff + COL_W'(1);
               end
            end else begin
               k_in = k_ff + COL_W'(1);
            end
         end
      endcase

      // writes to the grid row and column registers restart the grid
      if (csr_accept) begin
         unique case (csr_index)
            REG_GRID_ROWS: begin
               grid_rows_in = csr_data;
               pos_r_in     = '0;
               pos_c_in     = '0;
               flags_in     = '0;
            end
            REG_GRID_COLS: begin
               grid_cols_in = csr_data;
               pos_r_in     = '0;
               pos_c_in     = '0;
               flags_in     = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // output register
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_tready);
   assign rsp_item_in  = out_load ? out_item : rsp_item_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         grid_rows_ff <= DIM_RESET;
         grid_cols_ff <= DIM_RESET;
         pos_r_ff     <= '0;
         pos_c_ff     <= '0;
         nd0_ff       <= '0;
         nd1_ff       <= '0;
         nd2_ff       <= '0;
         flags_ff     <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         grid_rows_ff <= grid_rows_in;
         grid_cols_ff <= grid_cols_in;
         pos_r_ff     <= pos_r_in;
         pos_c_ff     <= pos_c_in;
         nd0_ff       <= nd0_in;
         nd1_ff       <= nd1_in;
         nd2_ff       <= nd2_in;
         flags_ff     <= flags_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      r_ff        <= r_in;
      c_ff        <= c_in;
      s_ff        <= s_in;
      ent_c_ff    <= ent_c_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_item_ff.last;
   assign rsp_tdata  = {RSP_PAD_W'(0), rsp_item_ff.col, rsp_item_ff.row};

   // a result is loaded only into a free output register
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("output register overwritten");

   // the final cell of a grid leads into the flag drain
   a_grid_end_flush: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && out_free && grid_end) |=> state_ff == ST_FLUSH)
      else $error("grid end did not start flag drain");

   // the last drained peak leaves no flag behind
   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && out_load && out_item.last) |=> flags_ff == '0)
      else $error("flags left after last bottom-row peak");

   // a decided peak reaches the output register
   a_peak_shown: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && out_free && pk) |=> rsp_valid_ff)
      else $error("peak lost");

endmodule

>>> hw/rtl/gpf_ram.sv
// ----------------------------------------------------------------------------
// gpf_ram: generic single-clock RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gpf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write, and hold read data until the next read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the grid local peak finder
// Streams grids of samples into the block and compares every reported peak
// with an in-bench prediction of the 4-neighbor maximum rule, ties included.
// Covers reset dimensions, tiny and widest grids, clamped register values,
// restarts by register writes, and random grids with random stalls.
// ----------------------------------------------------------------------------
module testbench
   import gpf_pkg::*;
();

   localparam int MAX_DIM       = 32;
   localparam int IDLE_PERCENT  = 10;
   localparam int SETTLE_CYCLES = 20;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_ITEMS  = 30;
   localparam int REPORT_LIMIT  = 10;

   // register indexes that select no register
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_B = 2'd3;

   typedef enum int {
      VALUES_FULL,
      VALUES_NARROW,
      VALUES_EXTREME
   } value_mode_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [15:0]            req_tdata  = '0;   // sample
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;         // peak_row, peak_col, zero pad
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CFG_W-1:0]       csr_data   = '0;

   bit steady = 1'b0;
   int peak_errors = 0;
   int cycle_count = 0;

   // predicted block state
   logic [CFG_W-1:0] rows_setting = DIM_RESET;
   logic [CFG_W-1:0] cols_setting = DIM_RESET;
   logic [15:0]      older_vals [MAX_DIM];
   logic [15:0]      prior_vals [MAX_DIM];
   logic [15:0]      delay_vals [3];
   int               next_row = 0;
   int               next_col = 0;
   bit               bottom_flags [MAX_DIM];

   rsp_item_type expected_peaks[$];

   grid_local_peak_finder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      foreach (older_vals[i]) begin
         older_vals[i]   = '0;
         prior_vals[i]   = '0;
         bottom_flags[i] = 1'b0;
      end
      foreach (delay_vals[i]) delay_vals[i] = '0;
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------
   function automatic int clamp_dim(input logic [CFG_W-1:0] v);
      if (v < DIM_MIN) return int'(DIM_MIN);
      if (v > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   function automatic void restart_grid();
      next_row = 0;
      next_col = 0;
      foreach (bottom_flags[i]) bottom_flags[i] = 1'b0;
   endfunction

   function automatic void apply_csr(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CFG_W-1:0] val);
      case (idx)
         REG_GRID_ROWS: begin
            rows_setting = val;
            restart_grid();
         end
         REG_GRID_COLS: begin
            cols_setting = val;
            restart_grid();
         end
         default: ;
      endcase
   endfunction

   function automatic void predict_peaks(input logic [15:0] s);
      int rows, cols, r, c;
      logic [15:0] ctr;
      bit is_peak;
      rsp_item_type hit;
      rsp_item_type found[$];
      rows = clamp_dim(rows_setting);
      cols = clamp_dim(cols_setting);
      r = next_row;
      c = next_col;
      if (r >= rows || c >= cols) begin
         r = 0;
         c = 0;
      end
      // decide the cell one row up in this column
      if (r >= 1) begin
         ctr = prior_vals[c];
         is_peak = ctr >= s;
         if (r >= 2 && ctr < older_vals[c]) is_peak = 1'b0;
         if (c >= 1 && ctr < delay_vals[0]) is_peak = 1'b0;
         if (c + 1 < cols && ctr < prior_vals[c + 1]) is_peak = 1'b0;
         if (is_peak) begin
            hit.row  = PEAK_ROW_W'(r - 1);
            hit.col  = PEAK_COL_W'(c);
            hit.last = 1'b0;
            found.push_back(hit);
         end
         delay_vals[0] = ctr;
         older_vals[c] = ctr;
      end
      prior_vals[c] = s;
      // bottom row: flag the cell to the left, and the corner at row end
      if (r == rows - 1) begin
         if (c >= 1) begin
            ctr = delay_vals[1];
            is_peak = ctr >= s && ctr >= older_vals[c - 1];
            if (c >= 2 && ctr < delay_vals[2]) is_peak = 1'b0;
            bottom_flags[c - 1] = is_peak;
         end
         if (c == cols - 1)
            bottom_flags[c] = s >= delay_vals[1] && s >= older_vals[c];
      end
      delay_vals[2] = delay_vals[1];
      delay_vals[1] = s;
      // advance position, drain bottom flags at grid end
      if (c + 1 >= cols) begin
         if (r + 1 >= rows) begin
            for (int k = 0; k < cols; k++) begin
               if (bottom_flags[k]) begin
                  hit.row  = PEAK_ROW_W'(r);
                  hit.col  = PEAK_COL_W'(k);
                  hit.last = 1'b0;
                  found.push_back(hit);
               end
            end
            restart_grid();
         end else begin
            next_row = r + 1;
            next_col = 0;
         end
      end else begin
         next_row = r;
         next_col = c + 1;
      end
      if (found.size() > 0) found[found.size() - 1].last = 1'b1;
      foreach (found[i]) expected_peaks.push_back(found[i]);
   endfunction

   // ------------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------------
   function automatic void check_peak();
      rsp_item_type want, got;
      logic [RSP_PAD_W-1:0] pad;
      got.row  = rsp_tdata[PEAK_ROW_W-1:0];
      got.col  = rsp_tdata[PEAK_ROW_W+PEAK_COL_W-1:PEAK_ROW_W];
      got.last = rsp_tlast;
      pad      = rsp_tdata[RSP_DATA_W-1:PEAK_ROW_W+PEAK_COL_W];
      if (expected_peaks.size() == 0) begin
         if (peak_errors < REPORT_LIMIT)
            $display("unexpected peak: row %0d col %0d last %0b",
                     got.row, got.col, got.last);
         peak_errors++;
      end else begin
         want = expected_peaks.pop_front();
         if (got !== want || pad !== '0) begin
            if (peak_errors < REPORT_LIMIT)
               $display("peak error: expected row %0d col %0d last %0b,",
                        want.row, want.col, want.last,
                        " got row %0d col %0d last %0b pad %0h",
                        got.row, got.col, got.last, pad);
            peak_errors++;
         end
      end
   endfunction

   // watch every transfer in the order the block sees them
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) apply_csr(csr_index, csr_data);
         if (req_tvalid && req_tready) predict_peaks(req_tdata);
         if (rsp_tvalid && rsp_tready) check_peak();
      end
   end

   // random result stalls
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // end a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   task automatic wait_idle();
      while (expected_peaks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CFG_W-1:0] val);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // one sample transfer; random idle cycles ahead of it
   task automatic send_sample(input logic [15:0] s);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // drop valid for one cycle after the run
   task automatic send_values(input logic [15:0] vals[$]);
      foreach (vals[i]) send_sample(vals[i]);
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] pick_sample(input value_mode_type mode);
      case (mode)
         VALUES_NARROW:  return 16'($urandom_range(0, 3));
         VALUES_EXTREME: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default:        return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic send_run(input int count, input value_mode_type mode);
      logic [15:0] vals[$];
      repeat (count) vals.push_back(pick_sample(mode));
      send_values(vals);
   endtask

   task automatic set_grid(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
      write_csr(REG_GRID_ROWS, rows);
      write_csr(REG_GRID_COLS, cols);
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // reset dimensions: row 0 and the start of row 1 of a 20 x 20 grid
   task automatic test_reset_dims();
      send_run(20 + 2, VALUES_NARROW);
      wait_idle();
   endtask

   task automatic test_small_grids();
      logic [15:0] vals[$];
      // all equal: every cell is a peak, four results in all
      set_grid(6'd2, 6'd2);
      vals = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
      send_values(vals);
      // extremes on the diagonal
      vals = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000};
      send_values(vals);
      // single high center
      set_grid(6'd3, 6'd3);
      vals = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF,
               16'h0000, 16'h0000, 16'h0000, 16'h0000};
      send_values(vals);
      // dimensions below the minimum act as 2
      set_grid(6'd1, 6'd0);
      vals = '{16'h0001, 16'h0002, 16'h0003, 16'h0004};
      send_values(vals);
   endtask

   // tallest and widest grids, with values above the maximum clamped; no idling
   task automatic test_max_dims();
      steady = 1'b1;
      set_grid(6'd32, 6'd0);
      send_run(MAX_DIM * 2, VALUES_NARROW);
      set_grid(6'd1, 6'd63);
      send_run(2 * MAX_DIM, VALUES_FULL);
      steady = 1'b0;
   endtask

   // writes to spare indexes keep the grid; real writes restart it
   task automatic test_restart();
      set_grid(6'd3, 6'd3);
      send_run(4, VALUES_NARROW);
      write_csr(REG_SPARE_A, 6'd3);
      write_csr(REG_SPARE_B, 6'd63);
      send_run(5, VALUES_NARROW);
      send_run(3, VALUES_EXTREME);
      write_csr(REG_GRID_COLS, 6'd3);
      send_run(4, VALUES_NARROW);
      write_csr(REG_GRID_ROWS, 6'd3);
      send_run(9, VALUES_NARROW);
   endtask

   task automatic test_random_grids();
      int sent, count;
      logic [CFG_W-1:0] rows, cols;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         steady = sent >= RANDOM_ITEMS / 3 && sent < 2 * RANDOM_ITEMS / 3;
         rows = CFG_W'($urandom_range(0, 7));
         if ($urandom_range(0, 7) == 0) begin
            cols = CFG_W'($urandom_range(0, 63));
            rows = CFG_W'($urandom_range(0, 3));
         end else begin
            cols = CFG_W'($urandom_range(2, 8));
         end
         set_grid(rows, cols);
         count = clamp_dim(rows) * clamp_dim(cols);
         // now and then break the grid off; the next write restarts it
         if ($urandom_range(0, 9) == 0) count = $urandom_range(1, count - 1);
         send_run(count, value_mode_type'($urandom_range(0, 2)));
         sent += count;
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_dims();
      test_small_grids();
      test_max_dims();
      test_restart();
      test_random_grids();
      wait_idle();
      if (peak_errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/gpf_pkg.sv
hw/rtl/gpf_ram.sv
hw/rtl/grid_local_peak_finder.sv
tb/testbench.sv
